[rtl/cgch_pkg.sv]
package cgch_pkg;

   localparam int CLAMP_LIMIT = 10;
   localparam int DIM         = CLAMP_LIMIT + 1;
   localparam int DEPTH       = DIM * DIM;
   localparam int IDX_W       = $clog2(DIM);
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = 32;
   localparam int FIELD_W     = 8;
   localparam int RC_W        = 4;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   localparam logic OP_CHANGE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [FIELD_W-1:0] SEL_ALL     = 8'd0;
   localparam logic [FIELD_W-1:0] SEL_REGULAR = 8'd1;

   typedef struct packed {
      logic               operation;
      logic [FIELD_W-1:0] old_goal;
      logic [FIELD_W-1:0] new_goal;
      logic [FIELD_W-1:0] old_all_copies;
      logic [FIELD_W-1:0] new_all_copies;
      logic [FIELD_W-1:0] old_regular_copies;
      logic [FIELD_W-1:0] new_regular_copies;
      logic [FIELD_W-1:0] matrix_select;
      logic [RC_W-1:0]    read_row;
      logic [RC_W-1:0]    read_col;
   } req_payload_type;

   typedef struct packed {
      cnt_type cell_value;
      cnt_type all_copies_total;
      cnt_type valid_copies_total;
      cnt_type missing_chunks;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WR_OLD,
      ST_WR_NEW,
      ST_READ
   } cgch_state_type;

   // values above the limit saturate at the limit
   function automatic idx_type clamp_idx(input logic [FIELD_W-1:0] v);
      if (v > FIELD_W'(CLAMP_LIMIT - 1)) begin
         return IDX_W'(CLAMP_LIMIT);
      end
      return IDX_W'(v);
   endfunction

   // row-major cell address
   function automatic addr_type cell_addr(input idx_type row, input idx_type col);
      return ADDR_W'(row) * ADDR_W'(DIM) + ADDR_W'(col);
   endfunction

endpackage

[rtl/cgch_if.sv]
interface cgch_req_if;
   import cgch_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cgch_rsp_if;
   import cgch_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/chunk_goal_copy_histogram_core.sv]
// channel    | role   | moves
// -----------+--------+-------------------------------------------------
// req_chan   | sink   | change or cell-read request
// rsp_chan   | source | cell value and the three running totals
//
// a read request reads its cell, then answers; a change request takes the
// steps that the single read port and single write port of each matrix memory
// allow: old cell read, old cell written back while the new cell is read, new cell written back
// synchronous reset clears the totals and the per-cell valid bits at once,
// so there is no clearing pass; a cell whose valid bit is clear reads zero
// a request is taken while an earlier response still waits; the final
// step holds until the response register is free

module chunk_goal_copy_histogram_core (
   input logic        clock,
   input logic        reset,
   cgch_req_if.sink   req_chan,
   cgch_rsp_if.source rsp_chan
);
   import cgch_pkg::*;

   // sequencer
   cgch_state_type state_ff, state_in;

   // matrix memories, all-copies and regular
   cnt_type mem_all [DEPTH];
   cnt_type mem_reg [DEPTH];
   logic [DEPTH-1:0] vld_all_ff;
   logic [DEPTH-1:0] vld_reg_ff;

   logic     re;
   addr_type raddr_all, raddr_reg;
   cnt_type  rdata_all_ff, rdata_reg_ff;
   logic     rvld_all_ff, rvld_reg_ff;
   logic     we;
   addr_type waddr_all, waddr_reg;
   cnt_type  wdata_all, wdata_reg;

   // addresses of the change under way
   addr_type old_all_ff, old_reg_ff, new_all_ff, new_reg_ff;
   addr_type old_all_in, old_reg_in, new_all_in, new_reg_in;
   logic     capture_change;

   // decremented old cells, forwarded when old and new cell coincide
   cnt_type dec_all_ff, dec_reg_ff, dec_all_in, dec_reg_in;
   logic    capture_dec;

   // read request selection
   logic rd_all_ff, rd_reg_ff, rd_all_in, rd_reg_in;
   logic capture_read;

   // running totals
   cnt_type wsum_all_ff, wsum_reg_ff, missing_ff;
   cnt_type wsum_all_in, wsum_reg_in, missing_in;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            rsp_load;
   logic            rsp_free;

   logic    accept;
   idx_type og, ng, oa, na, orr, nr;
   logic    rd_in_range;
   addr_type rd_addr;
   cnt_type cur_all, cur_reg;
   cnt_type new_cur_all, new_cur_reg;
   logic    miss_sub, miss_add;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // clamped change fields
   assign og  = clamp_idx(req_chan.payload.old_goal);
   assign ng  = clamp_idx(req_chan.payload.new_goal);
   assign oa  = clamp_idx(req_chan.payload.old_all_copies);
   assign na  = clamp_idx(req_chan.payload.new_all_copies);
   assign orr = clamp_idx(req_chan.payload.old_regular_copies);
   assign nr  = clamp_idx(req_chan.payload.new_regular_copies);

   assign rd_in_range = (FIELD_W'(req_chan.payload.read_row) <= FIELD_W'(CLAMP_LIMIT)) &&
                        (FIELD_W'(req_chan.payload.read_col) <= FIELD_W'(CLAMP_LIMIT));
   assign rd_addr     = cell_addr(IDX_W'(req_chan.payload.read_row),
                                  IDX_W'(req_chan.payload.read_col));

   // a never-written cell counts as zero
   assign cur_all = rvld_all_ff ? rdata_all_ff : '0;
   assign cur_reg = rvld_reg_ff ? rdata_reg_ff : '0;

   assign new_cur_all = (new_all_ff == old_all_ff) ? dec_all_ff : cur_all;
   assign new_cur_reg = (new_reg_ff == old_reg_ff) ? dec_reg_ff : cur_reg;

   assign miss_sub = (og != '0) && (oa == '0);
   assign miss_add = (ng != '0) && (na == '0);

   always_comb begin
      state_in       = state_ff;
      re             = 1'b0;
      raddr_all      = old_all_ff;
      raddr_reg      = old_reg_ff;
      we             = 1'b0;
      waddr_all      = old_all_ff;
      waddr_reg      = old_reg_ff;
      wdata_all      = cur_all - CNT_W'(1);
      wdata_reg      = cur_reg - CNT_W'(1);
      capture_change = 1'b0;
      capture_dec    = 1'b0;
      capture_read   = 1'b0;
      rsp_load       = 1'b0;
      old_all_in     = cell_addr(og, oa);
      old_reg_in     = cell_addr(og, orr);
      new_all_in     = cell_addr(ng, na);
      new_reg_in     = cell_addr(ng, nr);
      dec_all_in     = cur_all - CNT_W'(1);
      dec_reg_in     = cur_reg - CNT_W'(1);
      rd_all_in      = rd_in_range && (req_chan.payload.matrix_select == SEL_ALL);
      rd_reg_in      = rd_in_range && (req_chan.payload.matrix_select == SEL_REGULAR);
      wsum_all_in    = wsum_all_ff;
      wsum_reg_in    = wsum_reg_ff;
      missing_in     = missing_ff;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               re = 1'b1;
               if (req_chan.payload.operation == OP_CHANGE) begin
                  // read old cells now, totals move straight away
                  raddr_all      = old_all_in;
                  raddr_reg      = old_reg_in;
                  capture_change = 1'b1;
                  wsum_all_in    = wsum_all_ff + CNT_W'(na) - CNT_W'(oa);
                  wsum_reg_in    = wsum_reg_ff + CNT_W'(nr) - CNT_W'(orr);
                  if (miss_add && !miss_sub) begin
                     missing_in = missing_ff + CNT_W'(1);
                  end else if (miss_sub && !miss_add) begin
                     missing_in = missing_ff - CNT_W'(1);
                  end
                  state_in = ST_WR_OLD;
               end else begin
                  raddr_all    = rd_addr;
                  raddr_reg    = rd_addr;
                  capture_read = 1'b1;
                  state_in     = ST_READ;
               end
            end
         end
         ST_WR_OLD: begin
            // write back decremented old cells, fetch new cells
            we          = 1'b1;
            re          = 1'b1;
            raddr_all   = new_all_ff;
            raddr_reg   = new_reg_ff;
            capture_dec = 1'b1;
            state_in    = ST_WR_NEW;
         end
         ST_WR_NEW: begin
            if (rsp_free) begin
               we                             = 1'b1;
               waddr_all                      = new_all_ff;
               waddr_reg                      = new_reg_ff;
               wdata_all                      = new_cur_all + CNT_W'(1);
               wdata_reg                      = new_cur_reg + CNT_W'(1);
               rsp_load                       = 1'b1;
               rsp_data_in.cell_value         = '0;
               rsp_data_in.all_copies_total   = wsum_all_ff;
               rsp_data_in.valid_copies_total = wsum_reg_ff;
               rsp_data_in.missing_chunks     = missing_ff;
               state_in                       = ST_IDLE;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               if (rd_all_ff) begin
                  rsp_data_in.cell_value = cur_all;
               end else if (rd_reg_ff) begin
                  rsp_data_in.cell_value = cur_reg;
               end else begin
                  rsp_data_in.cell_value = '0;
               end
               rsp_data_in.all_copies_total   = wsum_all_ff;
               rsp_data_in.valid_copies_total = wsum_reg_ff;
               rsp_data_in.missing_chunks     = missing_ff;
               state_in                       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wsum_all_ff  <= '0;
         wsum_reg_ff  <= '0;
         missing_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wsum_all_ff  <= wsum_all_in;
         wsum_reg_ff  <= wsum_reg_in;
         missing_ff   <= missing_in;
      end
   end

   // per-cell valid bits stand in for the all-zero reset of the memories
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_all_ff <= '0;
         vld_reg_ff <= '0;
      end else if (we) begin
         vld_all_ff[waddr_all] <= 1'b1;
         vld_reg_ff[waddr_reg] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_all[waddr_all] <= wdata_all;
         mem_reg[waddr_reg] <= wdata_reg;
      end
      if (re) begin
         rdata_all_ff <= mem_all[raddr_all];
         rdata_reg_ff <= mem_reg[raddr_reg];
         rvld_all_ff  <= vld_all_ff[raddr_all];
         rvld_reg_ff  <= vld_reg_ff[raddr_reg];
      end
   end

   always_ff @(posedge clock) begin
      if (capture_change) begin
         old_all_ff <= old_all_in;
         old_reg_ff <= old_reg_in;
         new_all_ff <= new_all_in;
         new_reg_ff <= new_reg_in;
      end
      if (capture_dec) begin
         dec_all_ff <= dec_all_in;
         dec_reg_ff <= dec_reg_in;
      end
      if (capture_read) begin
         rd_all_ff <= rd_all_in;
         rd_reg_ff <= rd_reg_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // a change request always goes on to the old-cell write-back
   a_change_seq: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.payload.operation == OP_CHANGE)) |=> (state_ff == ST_WR_OLD))
      else $error("change request did not enter write-back");

   // a waiting response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response overwritten before it was taken");

   // memories are only written during a change sequence
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      we |-> ((state_ff == ST_WR_OLD) || (state_ff == ST_WR_NEW)))
      else $error("memory write outside change sequence");

   // totals move only when a change request is taken
   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && (req_chan.payload.operation == OP_CHANGE)) |=>
      ($stable(wsum_all_ff) && $stable(wsum_reg_ff) && $stable(missing_ff)))
      else $error("totals changed without a change request");

endmodule
